/* src/cpi_pkg.sv */
// cpi_pkg: shared constants for the colour palette indexer
// palette depth and the widths that follow from it, plus the colour and port widths; no dependencies
package cpi_pkg;

   localparam int PALETTE_DEPTH = 256;
   localparam int ADDR_W        = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
   localparam int COUNT_W       = $clog2(PALETTE_DEPTH + 1);

   localparam int CHAN_W        = 8;
   localparam int COLOR_W       = 3 * CHAN_W;
   localparam int INDEX_W       = 8;
   localparam int SIZE_W        = 9;

   localparam int REQ_DATA_W    = 24;
   localparam int RSP_DATA_W    = 24;
   localparam int RSP_USER_W    = 2;

   typedef logic [COLOR_W-1:0] color_type;
   typedef logic [ADDR_W-1:0]  addr_type;
   typedef logic [COUNT_W-1:0] count_type;

endpackage

/* src/color_palette_indexer.sv */
// color_palette_indexer: builds an indexed colour palette from a pixel stream
// depends on cpi_pkg and cpi_ram
//
// usage:
//   req channel: one pixel per request, tdata = {blue, green, red} (red lowest),
//   tuser = start of image, which empties the palette before the pixel is handled
//   rsp channel: one result per request with the palette index, the palette size
//   after the pixel and two flags (new entry, overflow) in tuser
//   the palette is searched in insertion order through one ram read port and one
//   24-bit comparator, one entry per cycle, reads and compares overlapped
//   a match ends the search at the first stored entry equal to the pixel;
//   a miss compares every stored entry, then the colour is written
//   a new pixel is taken only after the previous one's result is registered;
//   a full palette holds 256 entries, and req_tready is low during the search
//   a new request is taken while the previous result still waits on rsp;
//   if the receiver stalls, the search finishes, then waits until the
//   result register is free before delivering and updating the palette
//   reset empties the palette and clears the result valid flag; no clearing pass
module color_palette_indexer (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // tdata: red [7:0], green [15:8], blue [23:16]
   input  logic [cpi_pkg::REQ_DATA_W-1:0]  req_tdata,
   // tuser: start_of_image [0]
   input  logic                            req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // tdata: color_index [7:0], palette_size [16:8], zero [23:17]
   output logic [cpi_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // tuser: new_entry [0], overflow [1]
   output logic [cpi_pkg::RSP_USER_W-1:0]  rsp_tuser
);
   import cpi_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SCAN = 1'b1;

   logic                state_ff, state_in;
   color_type           color_ff, color_in;
   count_type           count_ff, count_in;
   count_type           scan_ff, scan_in;
   logic                cmp_valid_ff, cmp_valid_in;
   addr_type            cmp_idx_ff, cmp_idx_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0]  rsp_index_ff, rsp_index_in;
   logic [SIZE_W-1:0]   rsp_size_ff, rsp_size_in;
   logic                rsp_new_ff, rsp_new_in;
   logic                rsp_ovf_ff, rsp_ovf_in;

   logic                req_fire;
   logic                match;
   logic                scan_done;
   logic                can_finish;
   logic                rd_en;
   logic                wr_en;
   color_type           rd_data;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign match      = cmp_valid_ff && (rd_data == color_ff);
   assign scan_done  = match || (scan_ff == count_ff);
   assign can_finish = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      color_in     = color_ff;
      count_in     = count_ff;
      scan_in      = scan_ff;
      cmp_valid_in = cmp_valid_ff;
      cmp_idx_in   = cmp_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_index_in = rsp_index_ff;
      rsp_size_in  = rsp_size_ff;
      rsp_new_in   = rsp_new_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rd_en        = 1'b0;
      wr_en        = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               color_in     = {req_tdata[2*CHAN_W +: CHAN_W],
                               req_tdata[CHAN_W +: CHAN_W],
                               req_tdata[0 +: CHAN_W]};
               if (req_tuser) begin
                  count_in = '0;
               end
               scan_in      = '0;
               cmp_valid_in = 1'b0;
               state_in     = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_done) begin
               // hold the search result until the output register is free
               if (can_finish) begin
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
                  priority if (match) begin
                     rsp_index_in = INDEX_W'(cmp_idx_ff);
                     rsp_new_in   = 1'b0;
                     rsp_ovf_in   = 1'b0;
                     rsp_size_in  = SIZE_W'(count_ff);
                  end else if (count_ff < count_type'(PALETTE_DEPTH)) begin
                     wr_en        = 1'b1;
                     count_in     = count_ff + 1'b1;
                     rsp_index_in = INDEX_W'(count_ff);
                     rsp_new_in   = 1'b1;
                     rsp_ovf_in   = 1'b0;
                     rsp_size_in  = SIZE_W'(count_ff + 1'b1);
                  end else begin
                     rsp_index_in = '0;
                     rsp_new_in   = 1'b0;
                     rsp_ovf_in   = 1'b1;
                     rsp_size_in  = SIZE_W'(count_ff);
                  end
               end
            end else begin
               // issue the next read, its compare happens next cycle
               rd_en        = 1'b1;
               cmp_valid_in = 1'b1;
               cmp_idx_in   = scan_ff[ADDR_W-1:0];
               scan_in      = scan_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      color_ff     <= color_in;
      scan_ff      <= scan_in;
      cmp_idx_ff   <= cmp_idx_in;
      rsp_index_ff <= rsp_index_in;
      rsp_size_ff  <= rsp_size_in;
      rsp_new_ff   <= rsp_new_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   cpi_ram #(
      .WIDTH (COLOR_W),
      .DEPTH (PALETTE_DEPTH)
   ) u_palette (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (color_ff),
      .rd_en   (rd_en),
      .rd_addr (scan_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - SIZE_W - INDEX_W)'(0), rsp_size_ff, rsp_index_ff};
   assign rsp_tuser  = {rsp_ovf_ff, rsp_new_ff};

endmodule

/* src/cpi_ram.sv */
// cpi_ram: generic single write port, single read port ram with registered read
// no dependencies; used for the palette store
module cpi_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic                             rd_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      // read register holds while no read is issued
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/cpi_checker.sv */
// cpi_checker: port-level assertions for color_palette_indexer
// depends on cpi_pkg; bound to the top level below
module cpi_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [cpi_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic [cpi_pkg::RSP_USER_W-1:0]  rsp_tuser
);
   import cpi_pkg::*;

   // a result waiting on the receiver stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp dropped while stalled");

   // an accepted request keeps the block busy for the search
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken during search");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[0] && rsp_tuser[1]))
      else $error("new entry and overflow together");

   a_overflow_index: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tdata[INDEX_W-1:0] == '0)
      else $error("overflow with non-zero index");

   a_new_entry_size: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[INDEX_W +: SIZE_W] != '0)
      else $error("new entry with empty palette");

endmodule

bind color_palette_indexer cpi_checker u_cpi_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

/* sim/tb_top.sv */
// tb_top: self-checking bench for color_palette_indexer, directed table then random images
// depends on cpi_pkg and the rtl; results checked against the table or a shadow palette
module tb_top;
   import cpi_pkg::*;

   localparam int RANDOM_PIXELS = 1680;
   localparam int CYCLE_LIMIT   = 2_500_000;
   localparam int HOLD_CYCLES   = 600;
   localparam int BIG_IMAGE_LEN = 300;

   typedef struct packed {
      logic [INDEX_W-1:0] color_index;
      logic               new_entry;
      logic               overflow;
      logic [SIZE_W-1:0]  palette_size;
   } palette_result_type;

   typedef struct packed {
      logic               sof;
      color_type          rgb;
      logic [8:0]         reps;
      logic               typed;
      palette_result_type want;
   } plan_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;

   // shadow copy of the palette, stored as {red, green, blue}
   color_type          shadow_colors [PALETTE_DEPTH];
   int                 shadow_count = 0;
   palette_result_type pending_results [$];
   plan_row_type       plan_rows [$];

   int mismatch_count = 0;
   int results_seen   = 0;
   int pixels_sent    = 0;
   int burst_left     = 0;
   int cycle_count    = 0;

   // receiver state
   logic [12:0] ready_pattern = 13'h1fff;
   int          ready_phase   = 0;
   int          hold_left     = 0;
   logic        hold_done     = 1'b0;
   int          taken_count   = 0;

   color_palette_indexer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // expected result of one pixel, updating the shadow palette
   function automatic palette_result_type index_pixel(logic sof, color_type rgb);
      palette_result_type r;
      int                 hit;
      int                 k;
      r   = '0;
      hit = -1;
      if (sof)
         shadow_count = 0;
      for (k = 0; k < shadow_count; k++) begin
         if (hit < 0 && shadow_colors[k] == rgb)
            hit = k;
      end
      if (hit >= 0) begin
         r.color_index = INDEX_W'(hit);
      end else if (shadow_count < PALETTE_DEPTH) begin
         r.color_index = INDEX_W'(shadow_count);
         shadow_colors[shadow_count] = rgb;
         shadow_count++;
         r.new_entry = 1'b1;
      end else begin
         r.overflow = 1'b1;
      end
      r.palette_size = SIZE_W'(shadow_count);
      return r;
   endfunction

   task automatic flag_mismatch(string field, int got, int want);
      mismatch_count++;
      $display("mismatch at result %0d: %s is %0h, expected %0h",
               results_seen, field, got, want);
   endtask

   task automatic add_row(logic sof, color_type rgb, int reps, logic typed,
                          int idx, logic added, logic full, int size);
      plan_row_type row;
      row.sof                = sof;
      row.rgb                = rgb;
      row.reps               = 9'(reps);
      row.typed              = typed;
      row.want.color_index   = INDEX_W'(idx);
      row.want.new_entry     = added;
      row.want.overflow      = full;
      row.want.palette_size  = SIZE_W'(size);
      plan_rows.push_back(row);
   endtask

   // offer one pixel request, wait for it to be taken, then maybe pause
   task automatic offer_pixel(logic sof, color_type rgb, logic typed,
                              palette_result_type want);
      palette_result_type got;
      int                 gap;
      req_tvalid <= 1'b1;
      req_tdata  <= {rgb[7:0], rgb[15:8], rgb[23:16]};
      req_tuser  <= sof;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      got = index_pixel(sof, rgb);
      pending_results.push_back(typed ? want : got);
      pixels_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                 : $urandom_range(0, 12);
      end
   endtask

   // receiver: rotating stall pattern, one long hold-off after a few hundred results
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            taken_count <= taken_count + 1;
         if (hold_left > 0) begin
            hold_left  <= hold_left - 1;
            rsp_tready <= 1'b0;
         end else if (!hold_done && taken_count >= 400) begin
            hold_done  <= 1'b1;
            hold_left  <= HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready  <= ready_pattern[ready_phase];
            ready_phase <= (ready_phase == 12) ? 0 : ready_phase + 1;
            if (ready_phase == 12 && $urandom_range(0, 3) == 0)
               ready_pattern <= ($urandom_range(0, 2) == 0) ? 13'h1fff
                                                            : (13'($urandom) | 13'h1);
         end
      end
   end

   always @(posedge clock) begin
      palette_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            flag_mismatch("result with nothing pending, tdata", int'(rsp_tdata), 0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata[INDEX_W-1:0] != want.color_index)
               flag_mismatch("color_index", int'(rsp_tdata[INDEX_W-1:0]),
                             int'(want.color_index));
            if (rsp_tdata[INDEX_W+SIZE_W-1:INDEX_W] != want.palette_size)
               flag_mismatch("palette_size", int'(rsp_tdata[INDEX_W+SIZE_W-1:INDEX_W]),
                             int'(want.palette_size));
            if (rsp_tdata[RSP_DATA_W-1:INDEX_W+SIZE_W] != '0)
               flag_mismatch("tdata padding", int'(rsp_tdata[RSP_DATA_W-1:INDEX_W+SIZE_W]), 0);
            if (rsp_tuser[0] != want.new_entry)
               flag_mismatch("new_entry", int'(rsp_tuser[0]), int'(want.new_entry));
            if (rsp_tuser[1] != want.overflow)
               flag_mismatch("overflow", int'(rsp_tuser[1]), int'(want.overflow));
         end
         results_seen++;
      end
   end

   initial begin
      plan_row_type row;
      color_type    pool [64];
      color_type    base;
      color_type    stride;
      color_type    rgb;
      int           pool_size;
      int           img_len;
      int           k;
      int           r;
      int           big_images;
      logic         paused;
      logic         sof;

      // pixels before any start of image, hits on both extremes
      add_row(1'b0, 24'h000000, 1, 1'b1, 0, 1'b1, 1'b0, 1);
      add_row(1'b0, 24'hffffff, 1, 1'b1, 1, 1'b1, 1'b0, 2);
      add_row(1'b0, 24'h000000, 1, 1'b1, 0, 1'b0, 1'b0, 2);
      add_row(1'b0, 24'hffffff, 1, 1'b1, 1, 1'b0, 1'b0, 2);
      // start of image empties the palette
      add_row(1'b1, 24'hffffff, 1, 1'b1, 0, 1'b1, 1'b0, 1);
      add_row(1'b0, 24'hff0000, 1, 1'b1, 1, 1'b1, 1'b0, 2);
      add_row(1'b0, 24'h00ff00, 1, 1'b1, 2, 1'b1, 1'b0, 3);
      add_row(1'b0, 24'h0000ff, 1, 1'b1, 3, 1'b1, 1'b0, 4);
      add_row(1'b1, 24'h123456, 1, 1'b1, 0, 1'b1, 1'b0, 1);
      // fill the remaining 255 entries with consecutive colours
      add_row(1'b0, 24'h010203, 255, 1'b0, 0, 1'b0, 1'b0, 0);
      // full palette: known colours at both ends, then new colours overflow
      add_row(1'b0, 24'h123456, 1, 1'b1, 0, 1'b0, 1'b0, 256);
      add_row(1'b0, 24'h010301, 1, 1'b1, 255, 1'b0, 1'b0, 256);
      add_row(1'b0, 24'habcdef, 1, 1'b1, 0, 1'b0, 1'b1, 256);
      add_row(1'b0, 24'hffffff, 1, 1'b1, 0, 1'b0, 1'b1, 256);
      add_row(1'b1, 24'habcdef, 1, 1'b1, 0, 1'b1, 1'b0, 1);
      add_row(1'b1, 24'habcdef, 1, 1'b1, 0, 1'b1, 1'b0, 1);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      for (r = 0; r < plan_rows.size(); r++) begin
         row = plan_rows[r];
         for (k = 0; k < row.reps; k++)
            offer_pixel(row.sof && k == 0, color_type'(row.rgb + k), row.typed, row.want);
      end

      big_images = 0;
      paused     = 1'b0;
      while (pixels_sent < plan_rows.size() + 254 + RANDOM_PIXELS) begin
         if (!paused && pixels_sent >= 1200) begin
            // let the block drain completely once
            paused = 1'b1;
            req_tvalid <= 1'b0;
            @(posedge clock);
            while (pending_results.size() != 0)
               @(posedge clock);
         end
         if (big_images < 2 && pixels_sent >= 600 + big_images * 700) begin
            // distinct colours along an odd stride: fills the palette, then overflows
            big_images++;
            base   = color_type'($urandom);
            stride = color_type'($urandom) | 24'h1;
            for (k = 0; k < BIG_IMAGE_LEN; k++)
               offer_pixel(k == 0, color_type'(base + stride * k), 1'b0, '0);
            for (k = 0; k < 40; k++)
               offer_pixel(1'b0, color_type'(base + stride * $urandom_range(0, BIG_IMAGE_LEN - 1)),
                           1'b0, '0);
         end else begin
            pool_size = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48)
                                                   : $urandom_range(1, 12);
            for (k = 0; k < pool_size; k++) begin
               // near neighbours differ in one bit to test exact matching
               if (k > 0 && $urandom_range(0, 1) == 1)
                  pool[k] = pool[$urandom_range(0, k - 1)]
                            ^ (color_type'(1) << $urandom_range(0, COLOR_W - 1));
               else
                  pool[k] = color_type'($urandom);
            end
            img_len = $urandom_range(1, 40);
            for (k = 0; k < img_len; k++) begin
               sof = (k == 0) ? ($urandom_range(0, 19) != 0) : ($urandom_range(0, 59) == 0);
               rgb = ($urandom_range(0, 6) == 0) ? color_type'($urandom)
                                                : pool[$urandom_range(0, pool_size - 1)];
               offer_pixel(sof, rgb, 1'b0, '0);
            end
         end
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (300) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
